@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the top module and apwa_ring.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define APWA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that pre at one edge is followed by post at the next edge.
`define APWA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/apwa_pkg.sv @@
package apwa_pkg;

    // Default window geometry and count limit
    localparam int DEF_SLOTS_SHORT = 10;
    localparam int DEF_SLOTS_MID   = 6;
    localparam int DEF_SLOTS_LONG  = 60;
    localparam int DEF_MAX_PULSES  = 500;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int DEB_W      = 8;
    localparam int CAL_W      = 12;
    localparam int COUNT_W    = 9;
    localparam int SUM_SHORT_W = 13;
    localparam int SUM_MID_W  = 15;
    localparam int SUM_LONG_W = 21;
    localparam int SPEED_W    = 21;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB       = 1'd1;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd3;
    localparam logic [CAL_W-1:0] CALIB_RESET    = 12'd330;

    // Event codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic                   pulse_accepted;
        logic [COUNT_W-1:0]     second_count;
        logic [SUM_SHORT_W-1:0] sum_short;
        logic [SUM_MID_W-1:0]   sum_mid;
        logic [SUM_LONG_W-1:0]  sum_long;
        logic [SPEED_W-1:0]     speed_short_mm_s;
        logic [SPEED_W-1:0]     speed_mid_mm_s;
        logic [SPEED_W-1:0]     speed_long_mm_s;
    } out_item_t;

    // Result fields that ride along the speed pipeline
    typedef struct packed {
        logic                   pulse_accepted;
        logic [COUNT_W-1:0]     second_count;
        logic [SUM_SHORT_W-1:0] sum_short;
        logic [SUM_MID_W-1:0]   sum_mid;
        logic [SUM_LONG_W-1:0]  sum_long;
    } side_t;

endpackage

@@ rtl/apwa_stream_if.sv @@
interface apwa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/anemometer_pulse_window_averager.sv @@
// Pipeline from input transaction to result: input register, calibration product, then
// the partial products and quotient of the reciprocal multiplication for the speed divisions.
// Throughput: one item per cycle; the input stalls only when every pipeline stage is full.
// Reset clears the pulse count, last edge time, ring indexes, running sums,
// and pipeline valids; ring slots read as zero until first written.
`include "assert_macros.svh"

module anemometer_pulse_window_averager import apwa_pkg::*; #(
    parameter int SLOTS_SHORT = DEF_SLOTS_SHORT,
    parameter int SLOTS_MID   = DEF_SLOTS_MID,
    parameter int SLOTS_LONG  = DEF_SLOTS_LONG,
    parameter int MAX_PULSES  = DEF_MAX_PULSES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    apwa_stream_if.sink           in_item,
    apwa_stream_if.source         out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int CNT_W   = $clog2(MAX_PULSES + 1);
    localparam int SUM_S_W = CNT_W + $clog2(SLOTS_SHORT);
    localparam int SUM_M_W = SUM_S_W + $clog2(SLOTS_MID);
    localparam int SUM_L_W = SUM_M_W + $clog2(SLOTS_LONG);
    localparam int P_S_W   = SUM_S_W + CAL_W;
    localparam int P_M_W   = SUM_M_W + CAL_W;
    localparam int P_L_W   = SUM_L_W + CAL_W;
    localparam int DIV_S   = SLOTS_SHORT;
    localparam int DIV_M   = SLOTS_SHORT * SLOTS_MID;
    localparam int DIV_L   = SLOTS_SHORT * SLOTS_MID * SLOTS_LONG;
    // Speed divider stages after the calibration product: partial products, then quotient
    localparam int STAGES  = 2;
    localparam int NST     = STAGES + 2;

    in_item_t  in_data;
    out_item_t out_data;

    logic [DEB_W-1:0]  debounce_reg;
    logic [CAL_W-1:0]  calib_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TIME_W-1:0] last_edge_reg;
    logic [TIME_W-1:0] last_edge_next;
    logic [TIME_W-1:0] diff;
    logic              in_acc;
    logic              accepted;
    logic              push_short;
    logic              wrap_short;
    logic              wrap_mid;
    logic              wrap_long;
    logic [SUM_S_W-1:0] sum_s_next;
    logic [SUM_M_W-1:0] sum_m_next;
    logic [SUM_L_W-1:0] sum_l_next;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;
    side_t          side_next;
    side_t          side_reg [NST];

    logic [SUM_S_W-1:0] sa_s_reg;
    logic [SUM_M_W-1:0] sa_m_reg;
    logic [SUM_L_W-1:0] sa_l_reg;
    logic [P_S_W-1:0]   prod_s_reg;
    logic [P_M_W-1:0]   prod_m_reg;
    logic [P_L_W-1:0]   prod_l_reg;
    logic [SPEED_W-1:0] q_s;
    logic [SPEED_W-1:0] q_m;
    logic [SPEED_W-1:0] q_l;

    assign in_data = in_item.data;
    assign in_acc  = in_item.valid && rdy[0];

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            calib_reg    <= CALIB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS: debounce_reg <= DEB_W'(cfg_data);
                CFG_CALIB:       calib_reg    <= CAL_W'(cfg_data);
            endcase
        end
    end

    // Debounce, count and tick handling
    always_comb
    begin
        diff           = in_data.time_ms - last_edge_reg;
        count_next     = count_reg;
        last_edge_next = last_edge_reg;
        accepted       = 1'b0;
        push_short     = 1'b0;
        if (in_acc)
        begin
            unique case (in_data.func)
                FUNC_EDGE:
                begin
                    if (diff > TIME_W'(debounce_reg))
                    begin
                        last_edge_next = in_data.time_ms;
                        if (count_reg < CNT_W'(MAX_PULSES))
                        begin
                            count_next = count_reg + 1'b1;
                            accepted   = 1'b1;
                        end
                    end
                end
                FUNC_TICK:
                begin
                    push_short = 1'b1;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_edge_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            last_edge_reg <= last_edge_next;
        end
    end

    // Cascaded rings: each wrap pushes the new window sum one level down
    apwa_ring #(
        .DEPTH (SLOTS_SHORT),
        .VAL_W (CNT_W),
        .SUM_W (SUM_S_W)
    ) u_ring_short (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_short),
        .val      (count_reg),
        .sum_next (sum_s_next),
        .wrap     (wrap_short)
    );

    apwa_ring #(
        .DEPTH (SLOTS_MID),
        .VAL_W (SUM_S_W),
        .SUM_W (SUM_M_W)
    ) u_ring_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (wrap_short),
        .val      (sum_s_next),
        .sum_next (sum_m_next),
        .wrap     (wrap_mid)
    );

    apwa_ring #(
        .DEPTH (SLOTS_LONG),
        .VAL_W (SUM_M_W),
        .SUM_W (SUM_L_W)
    ) u_ring_long (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (wrap_mid),
        .val      (sum_m_next),
        .sum_next (sum_l_next),
        .wrap     (wrap_long)
    );

    always_comb
    begin
        side_next.pulse_accepted = accepted;
        side_next.second_count   = COUNT_W'(count_next);
        side_next.sum_short      = SUM_SHORT_W'(sum_s_next);
        side_next.sum_mid        = SUM_MID_W'(sum_m_next);
        side_next.sum_long       = SUM_LONG_W'(sum_l_next);
    end

    // A stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        rdy[NST] = out_item.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_item.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            side_reg[0] <= side_next;
            sa_s_reg    <= sum_s_next;
            sa_m_reg    <= sum_m_next;
            sa_l_reg    <= sum_l_next;
        end
        if (rdy[1])
        begin
            prod_s_reg <= P_S_W'(sa_s_reg) * P_S_W'(calib_reg);
            prod_m_reg <= P_M_W'(sa_m_reg) * P_M_W'(calib_reg);
            prod_l_reg <= P_L_W'(sa_l_reg) * P_L_W'(calib_reg);
        end
        for (int k = 1; k < NST; k++)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    apwa_cdiv #(
        .X_W     (P_S_W),
        .DIVISOR (DIV_S),
        .Q_W     (SPEED_W)
    ) u_div_short (
        .clk (clk),
        .en  (rdy[2 +: STAGES]),
        .x   (prod_s_reg),
        .q   (q_s)
    );

    apwa_cdiv #(
        .X_W     (P_M_W),
        .DIVISOR (DIV_M),
        .Q_W     (SPEED_W)
    ) u_div_mid (
        .clk (clk),
        .en  (rdy[2 +: STAGES]),
        .x   (prod_m_reg),
        .q   (q_m)
    );

    apwa_cdiv #(
        .X_W     (P_L_W),
        .DIVISOR (DIV_L),
        .Q_W     (SPEED_W)
    ) u_div_long (
        .clk (clk),
        .en  (rdy[2 +: STAGES]),
        .x   (prod_l_reg),
        .q   (q_l)
    );

    always_comb
    begin
        out_data.pulse_accepted   = side_reg[NST-1].pulse_accepted;
        out_data.second_count     = side_reg[NST-1].second_count;
        out_data.sum_short        = side_reg[NST-1].sum_short;
        out_data.sum_mid          = side_reg[NST-1].sum_mid;
        out_data.sum_long         = side_reg[NST-1].sum_long;
        out_data.speed_short_mm_s = q_s;
        out_data.speed_mid_mm_s   = q_m;
        out_data.speed_long_mm_s  = q_l;
    end

    assign in_item.ready  = rdy[0];
    assign out_item.valid = v_reg[NST-1];
    assign out_item.data  = out_data;

    `APWA_ASSERT(a_count_max, clk, rst_n, count_reg <= CNT_W'(MAX_PULSES), "pulse count above limit")
    `APWA_ASSERT_NEXT(a_tick_clears, clk, rst_n, in_acc && (in_data.func == FUNC_TICK), count_reg == '0, "tick did not clear count")
    `APWA_ASSERT(a_stall_full, clk, rst_n, !rdy[0] |-> (&v_reg), "input stalled with a free stage")
    `APWA_ASSERT(a_long_wrap, clk, rst_n, !wrap_long || wrap_mid, "long ring wrapped without a push")
endmodule

@@ rtl/apwa_ram.sv @@
module apwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/apwa_ring.sv @@
`include "assert_macros.svh"

module apwa_ring #(
    parameter int DEPTH = 10,
    parameter int VAL_W = 9,
    parameter int SUM_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [VAL_W-1:0] val,
    output logic [SUM_W-1:0] sum_next,
    output logic             wrap
);
    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             filled_reg;
    logic [SUM_W-1:0] run_reg;
    logic [VAL_W-1:0] rd_data;
    logic [VAL_W-1:0] old_val;
    logic             last;

    // The read port prefetches the slot at the next index, so the slot about
    // to be overwritten is always at hand.
    apwa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (idx_reg),
        .wdata (val),
        .raddr (idx_next),
        .rdata (rd_data)
    );

    assign last = (idx_reg == IDX_W'(DEPTH - 1));
    assign wrap = push && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (push)
        begin
            idx_next = last ? '0 : idx_reg + 1'b1;
        end
        // Slots are written in order: until the first wrap, the current one is empty.
        old_val  = filled_reg ? rd_data : '0;
        sum_next = push ? (run_reg - SUM_W'(old_val) + SUM_W'(val)) : run_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            filled_reg <= 1'b0;
            run_reg    <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            run_reg <= sum_next;
            if (wrap)
            begin
                filled_reg <= 1'b1;
            end
        end
    end

    `APWA_ASSERT(a_idx_range, clk, rst_n, idx_reg <= IDX_W'(DEPTH - 1), "ring index out of range")
    `APWA_ASSERT_NEXT(a_wrap_fills, clk, rst_n, wrap, (idx_reg == '0) && filled_reg, "ring wrap lost")
endmodule

@@ rtl/apwa_cdiv.sv @@
module apwa_cdiv #(
    parameter int X_W     = 25,
    parameter int DIVISOR = 10,
    parameter int Q_W     = 21
) (
    input  logic           clk,
    input  logic [1:0]     en,
    input  logic [X_W-1:0] x,
    output logic [Q_W-1:0] q
);
    // Multiply by ceil(2^S / DIVISOR) and drop S bits. With S = X_W + clog2(DIVISOR)
    // the rounding error stays below one quotient step for every X_W-bit input.
    localparam int S    = X_W + $clog2(DIVISOR);
    localparam int C_W  = S + 2;
    localparam int M_W  = X_W + 2;
    localparam int LO_W = M_W / 2;
    localparam int HI_W = M_W - LO_W;
    localparam int LP_W = X_W + LO_W;
    localparam int HP_W = X_W + HI_W;
    localparam int F_W  = X_W + M_W;
    localparam logic [C_W-1:0] ONE_S  = C_W'(1) << S;
    localparam logic [C_W-1:0] M_FULL = (ONE_S + C_W'(DIVISOR - 1)) / C_W'(DIVISOR);
    localparam logic [M_W-1:0] RECIP  = M_W'(M_FULL);
    localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP[M_W-1:LO_W];

    logic [LP_W-1:0] pp_lo_reg;
    logic [HP_W-1:0] pp_hi_reg;
    logic [F_W-1:0]  prod_sum;
    logic [Q_W-1:0]  q_next;
    logic [Q_W-1:0]  q_reg;

    // Split the reciprocal so each multiplier stays narrow; recombine from the registered partial products
    assign prod_sum = {pp_hi_reg, {LO_W{1'b0}}} + F_W'(pp_lo_reg);
    assign q_next   = Q_W'(prod_sum >> S);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pp_lo_reg <= LP_W'(x) * LP_W'(RECIP_LO);
            pp_hi_reg <= HP_W'(x) * HP_W'(RECIP_HI);
        end
        if (en[1])
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule
